// ===== hw/rtl/range_second_minimum_query_top_defines.svh =====
// Assertion macros shared by the range second-minimum query RTL.
// Included by modules that carry concurrent assertions; depends on nothing.
`ifndef RANGE_SECOND_MINIMUM_QUERY_TOP_DEFINES_SVH
`define RANGE_SECOND_MINIMUM_QUERY_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RSMQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rsmq assertion failed");
`define RSMQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rsmq assertion failed");
`else
`define RSMQ_ASSERT(lbl, clk, rst, prop)
`define RSMQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/rsmq_pkg.sv =====
// Shared types and fixed field widths of the range second-minimum query block.
// No dependencies.
`default_nettype none
package rsmq_pkg;
   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned INDEX_WIDTH = 10;
   localparam int unsigned COUNT_WIDTH = 11;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_BUILD,
      CMD_QUERY,
      CMD_ERROR
   } cmd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QDATA,
      ST_GAP,
      ST_BUILD
   } back_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rsmq_front.sv =====
// Front end: accepts transactions, tracks load position and table state,
// and classifies each item into a command. Depends on rsmq_pkg.
`default_nettype none
module rsmq_front #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 10,
   parameter int VALUE_WIDTH  = 32,
   parameter int JW           = $clog2(MAX_ELEMENTS),
   parameter int LW           = (LEVELS > 1) ? $clog2(LEVELS) : 1,
   parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write_enable,
   input  wire [rsmq_pkg::COUNT_WIDTH-1:0]        csr_write_data,
   input  wire                                    accept,
   input  wire                                    req_operation,
   input  wire signed [rsmq_pkg::FIELD_WIDTH-1:0] req_element_value,
   input  wire [rsmq_pkg::INDEX_WIDTH-1:0]        req_left_index,
   input  wire [rsmq_pkg::INDEX_WIDTH-1:0]        req_right_index,
   output rsmq_pkg::cmd_op_type                   cmd_op,
   output logic [LW+JW-1:0]                       cmd_addr_a,
   output logic [LW+JW-1:0]                       cmd_addr_b,
   output logic [VALUE_WIDTH-1:0]                 cmd_value,
   output logic [CW-1:0]                          cmd_count
);
   import rsmq_pkg::*;

   localparam logic [CW-1:0] RESET_COUNT = CW'((MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          ready_ff, ready_in;

   logic [CW-1:0]          cur_pos, next_pos;
   logic [INDEX_WIDTH-1:0] len_m1, b_idx;
   logic [3:0]             level;
   logic                   bad_range, level_over;

   always_comb begin
      cur_pos  = (ready_ff || (pos_ff >= count_ff)) ? '0 : pos_ff;
      next_pos = cur_pos + CW'(1);
      len_m1   = req_right_index - req_left_index;
      level    = 4'd0;
      for (int i = 1; i < INDEX_WIDTH; i++) begin
         if (len_m1[i]) begin
            level = 4'(i);
         end
      end
      b_idx      = req_right_index - ((INDEX_WIDTH'(1) << level) - INDEX_WIDTH'(1));
      bad_range  = !ready_ff || (req_left_index > req_right_index) ||
                   (32'(req_right_index) >= 32'(count_ff));
      level_over = 32'(level) >= LEVELS;
   end

   always_comb begin
      cmd_count = count_ff;
      cmd_value = VALUE_WIDTH'($unsigned(req_element_value)) ^
                  {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      if (!req_operation) begin
         cmd_op     = (next_pos >= count_ff) ? CMD_BUILD : CMD_LOAD;
         cmd_addr_a = {LW'(0), JW'(cur_pos)};
         cmd_addr_b = {LW'(0), JW'(cur_pos)};
      end else begin
         cmd_op     = (bad_range || level_over) ? CMD_ERROR : CMD_QUERY;
         cmd_addr_a = {LW'(level), JW'(req_left_index)};
         cmd_addr_b = {LW'(level), JW'(b_idx)};
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      ready_in = ready_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            count_in = CW'(1);
         end else if (32'(csr_write_data) > 32'(MAX_ELEMENTS)) begin
            count_in = CW'(MAX_ELEMENTS);
         end else begin
            count_in = CW'(csr_write_data);
         end
         pos_in   = '0;
         ready_in = 1'b0;
      end else if (accept && !req_operation) begin
         if (next_pos >= count_ff) begin
            pos_in   = '0;
            ready_in = 1'b1;
         end else begin
            pos_in   = next_pos;
            ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RESET_COUNT;
         pos_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         ready_ff <= ready_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rsmq_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on rsmq_pkg and the assertion macro header.
`default_nettype none
`include "range_second_minimum_query_top_defines.svh"
module rsmq_queue #(
   parameter int WIDTH = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire [WIDTH-1:0]            push_data,
   input  wire                        pop,
   output logic [WIDTH-1:0]           pop_data,
   output rsmq_pkg::queue_status_type status
);
   import rsmq_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, rd_ptr_ff;

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   `RSMQ_ASSERT(a_no_overflow, clock, reset, push |-> !status.full || pop)
   `RSMQ_ASSERT(a_no_underflow, clock, reset, pop |-> !status.empty)
   `RSMQ_ASSERT(a_count_bound, clock, reset, count_ff != 2'd3)
endmodule
`default_nettype wire

// ===== hw/rtl/rsmq_back.sv =====
// Back end: holds the sparse table memory, writes loads, builds the upper
// levels and answers queries. Depends on rsmq_pkg and the assertion header.
`default_nettype none
`include "range_second_minimum_query_top_defines.svh"
module rsmq_back #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 10,
   parameter int VALUE_WIDTH  = 32,
   parameter int JW           = $clog2(MAX_ELEMENTS),
   parameter int LW           = (LEVELS > 1) ? $clog2(LEVELS) : 1,
   parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  rsmq_pkg::cmd_op_type                    cmd_op,
   input  wire [LW+JW-1:0]                         cmd_addr_a,
   input  wire [LW+JW-1:0]                         cmd_addr_b,
   input  wire [VALUE_WIDTH-1:0]                   cmd_value,
   input  wire [CW-1:0]                            cmd_count,
   input  rsmq_pkg::queue_status_type              status,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic signed [rsmq_pkg::FIELD_WIDTH-1:0] rsp_second_minimum,
   output logic                                    rsp_query_error
);
   import rsmq_pkg::*;

   localparam int AW  = LW + JW;
   localparam int PW  = 2 * VALUE_WIDTH;
   localparam int LVW = LW + 1;
   localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Returns {minimum, second distinct minimum or minimum} of two pairs.
   function automatic logic [PW-1:0] merge_pairs(input logic [PW-1:0] a,
                                                 input logic [PW-1:0] b);
      logic [VALUE_WIDTH-1:0] v [4];
      logic [VALUE_WIDTH-1:0] lo, nx;
      logic                   found;
      v[0] = a[PW-1:VALUE_WIDTH];
      v[1] = a[VALUE_WIDTH-1:0];
      v[2] = b[PW-1:VALUE_WIDTH];
      v[3] = b[VALUE_WIDTH-1:0];
      lo = v[0];
      for (int i = 1; i < 4; i++) begin
         if (v[i] < lo) begin
            lo = v[i];
         end
      end
      nx    = lo;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if ((v[i] != lo) && (!found || (v[i] < nx))) begin
            nx    = v[i];
            found = 1'b1;
         end
      end
      return {lo, nx};
   endfunction

   logic [PW-1:0] level_mem [LEVELS*(2**JW)];

   back_state_type state_ff, state_in;

   logic [LVW-1:0] lv_ff, lv_in;
   logic [JW-1:0]  j_ff, j_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           wr_pend_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic [PW-1:0]  rd_a_ff, rd_b_ff;
   logic           rsp_valid_ff;
   logic [FIELD_WIDTH-1:0] rsp_data_ff;
   logic           rsp_err_ff;

   logic          out_free, load_we, rd_en, build_step, build_start, rsp_load, rsp_err;
   logic [31:0]   span, last_j;
   logic [AW-1:0] rd_addr_a, rd_addr_b, build_addr_a, build_addr_b;
   logic [PW-1:0] merged;
   logic [VALUE_WIDTH-1:0] answer;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign span     = 32'(1) << lv_ff;
   assign last_j   = 32'(n_ff) - span;
   assign merged   = merge_pairs(rd_a_ff, rd_b_ff);
   assign answer   = merged[VALUE_WIDTH-1:0] ^ SIGN_BIT;

   always_comb begin
      build_addr_a = {LW'(lv_ff - LVW'(1)), j_ff};
      build_addr_b = {LW'(lv_ff - LVW'(1)), j_ff + JW'(span >> 1)};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!status.empty) begin
               if (cmd_op == CMD_BUILD) begin
                  state_in = ST_GAP;
               end else if (cmd_op == CMD_QUERY) begin
                  state_in = ST_QDATA;
               end
            end
         end
         ST_QDATA: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_GAP: begin
            if ((32'(lv_ff) >= LEVELS) || (span > 32'(n_ff))) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (32'(j_ff) == last_j) begin
               state_in = ST_GAP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop         = 1'b0;
      load_we     = 1'b0;
      rd_en       = 1'b0;
      build_step  = 1'b0;
      build_start = 1'b0;
      rsp_load    = 1'b0;
      rsp_err     = 1'b0;
      rd_addr_a   = cmd_addr_a;
      rd_addr_b   = cmd_addr_b;
      case (state_ff)
         ST_IDLE: begin
            if (!status.empty) begin
               case (cmd_op)
                  CMD_LOAD: begin
                     pop     = 1'b1;
                     load_we = 1'b1;
                  end
                  CMD_BUILD: begin
                     pop         = 1'b1;
                     load_we     = 1'b1;
                     build_start = 1'b1;
                  end
                  CMD_QUERY: begin
                     pop   = 1'b1;
                     rd_en = 1'b1;
                  end
                  CMD_ERROR: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        rsp_load = 1'b1;
                        rsp_err  = 1'b1;
                     end
                  end
                  default: pop = 1'b0;
               endcase
            end
         end
         ST_QDATA: begin
            rsp_load = out_free;
         end
         ST_BUILD: begin
            rd_en      = 1'b1;
            build_step = 1'b1;
            rd_addr_a  = build_addr_a;
            rd_addr_b  = build_addr_b;
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_comb begin
      lv_in = lv_ff;
      j_in  = j_ff;
      n_in  = n_ff;
      if (build_start) begin
         lv_in = LVW'(1);
         j_in  = '0;
         n_in  = cmd_count;
      end else if (build_step) begin
         if (32'(j_ff) == last_j) begin
            lv_in = lv_ff + LVW'(1);
            j_in  = '0;
         end else begin
            j_in = j_ff + JW'(1);
         end
      end
   end

   // Table memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         level_mem[wr_addr_ff] <= merged;
      end else if (load_we) begin
         level_mem[cmd_addr_a] <= {cmd_value, cmd_value};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= level_mem[rd_addr_a];
         rd_b_ff <= level_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      lv_ff      <= lv_in;
      j_ff       <= j_in;
      n_ff       <= n_in;
      wr_addr_ff <= {LW'(lv_ff), j_ff};
      if (rsp_load) begin
         rsp_data_ff <= rsp_err ? '0 : FIELD_WIDTH'(answer);
         rsp_err_ff  <= rsp_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_pend_ff <= build_step;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_second_minimum = $signed(rsp_data_ff);
   assign rsp_query_error    = rsp_err_ff;

   `RSMQ_ASSERT(a_build_flow, clock, reset, state_ff == ST_BUILD |=> state_ff == ST_BUILD || state_ff == ST_GAP)
   `RSMQ_ASSERT(a_write_exclusive, clock, reset, wr_pend_ff |-> !load_we)
   `RSMQ_ASSERT(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall |-> !rsp_load)
endmodule
`default_nettype wire

// ===== hw/rtl/range_second_minimum_query_top.sv =====
// Range second-minimum query block: top level.
// Channels: req_* carries loads (operation 0) and range queries (operation 1);
// rsp_* returns one transaction per query, none per load. Both use valid and
// stall; a transaction moves when valid is high and stall is low.
// csr_write_enable with csr_write_data sets element_count and restarts loading.
// The back end writes each load as it pops it. The load that fills the array
// starts a build that walks the table level by level, limited by the table
// memory's single write port.
// A query goes through two steps (memory read, then merge into the output register),
// and the back end takes no new command until that response is loaded, which waits
// while rsp_* is stalled. Errors go from the queue straight into the output register.
// A two-entry command queue lets req_* keep going while rsp_* is stalled or a
// build runs; req_stall rises only when that queue is full.
// Reset is synchronous: it empties the queue, drops any pending response and
// marks the table as not built. Table contents are not cleared.
// While rsp_stall is high the response holds and the next query waits.
// Depends on rsmq_pkg, rsmq_front, rsmq_queue and rsmq_back.
`default_nettype none
module range_second_minimum_query_top #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 10,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_write_enable,
   input  wire [rsmq_pkg::COUNT_WIDTH-1:0]         csr_write_data,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire                                     req_operation,
   input  wire signed [rsmq_pkg::FIELD_WIDTH-1:0]  req_element_value,
   input  wire [rsmq_pkg::INDEX_WIDTH-1:0]         req_left_index,
   input  wire [rsmq_pkg::INDEX_WIDTH-1:0]         req_right_index,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic signed [rsmq_pkg::FIELD_WIDTH-1:0] rsp_second_minimum,
   output logic                                    rsp_query_error
);
   import rsmq_pkg::*;

   localparam int JW = $clog2(MAX_ELEMENTS);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int AW = LW + JW;
   localparam int QW = 2 + 2 * AW + VALUE_WIDTH + CW;

   cmd_op_type             f_op, b_op;
   logic [AW-1:0]          f_addr_a, f_addr_b, b_addr_a, b_addr_b;
   logic [VALUE_WIDTH-1:0] f_value, b_value;
   logic [CW-1:0]          f_count, b_count;
   logic [QW-1:0]          q_out;
   queue_status_type       q_status;
   logic                   accept, pop;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   rsmq_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS), .VALUE_WIDTH(VALUE_WIDTH),
      .JW(JW), .LW(LW), .CW(CW)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .accept(accept), .req_operation(req_operation),
      .req_element_value(req_element_value),
      .req_left_index(req_left_index), .req_right_index(req_right_index),
      .cmd_op(f_op), .cmd_addr_a(f_addr_a), .cmd_addr_b(f_addr_b),
      .cmd_value(f_value), .cmd_count(f_count)
   );

   rsmq_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .push(accept), .push_data({f_op, f_addr_a, f_addr_b, f_value, f_count}),
      .pop(pop), .pop_data(q_out), .status(q_status)
   );

   assign b_op     = cmd_op_type'(q_out[QW-1 -: 2]);
   assign b_addr_a = q_out[QW-3 -: AW];
   assign b_addr_b = q_out[QW-3-AW -: AW];
   assign b_value  = q_out[CW+VALUE_WIDTH-1 -: VALUE_WIDTH];
   assign b_count  = q_out[CW-1:0];

   rsmq_back #(
      .MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS), .VALUE_WIDTH(VALUE_WIDTH),
      .JW(JW), .LW(LW), .CW(CW)
   ) u_back (
      .clock(clock), .reset(reset),
      .cmd_op(b_op), .cmd_addr_a(b_addr_a), .cmd_addr_b(b_addr_b),
      .cmd_value(b_value), .cmd_count(b_count), .status(q_status), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_second_minimum(rsp_second_minimum), .rsp_query_error(rsp_query_error)
   );
endmodule
`default_nettype wire
